// ----- rtl/jac_pkg.sv -----
// Package for the job admission controller.
// Holds store sizes, command and status codes, and the controller/datapath link types.
// No dependencies.
package jac_pkg;

	localparam int WAIT_DEPTH = 16;
	localparam int RUN_SLOTS  = 8;

	localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
	localparam int RUN_AW  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int RUN_CW  = $clog2(RUN_SLOTS + 1);
	localparam int PTR_W   = (WAIT_CW > RUN_CW) ? WAIT_CW : RUN_CW;

	localparam int ID_W    = 16;
	localparam int MEM_W   = 16;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 3;
	localparam int LIMIT_W = 4;
	localparam int CNT_W   = 4;
	localparam int PADDR_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_KILL   = 2'd1;

	localparam logic [STAT_W-1:0] ST_CREATED      = 3'd0;
	localparam logic [STAT_W-1:0] ST_KILLED_WAIT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_KILLED_RUN   = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_QUEUE_FULL   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOOP         = 3'd5;

	localparam logic REG_MEM_CAPACITY = 1'b0;
	localparam logic REG_MAX_RUNNING  = 1'b1;

	typedef struct packed {
		logic load;
		logic create;
		logic w_step;
		logic w_kill;
		logic r_start;
		logic r_step;
		logic r_kill;
		logic not_found;
		logic admit;
	} jac_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              w_end;
		logic              w_hit;
		logic              r_end;
		logic              r_hit;
		logic              out_free;
	} jac_sts_t;

endpackage

// ----- rtl/job_admission_controller.sv -----
// Top level of the job admission controller.
// Holds the configuration registers and joins jac_ctrl and jac_dp. Uses jac_pkg.
//
// One command enters per transaction on the slave side and yields exactly one result
// transaction on the master side. A create or an admission-only command goes from
// decode straight to admission; a kill walks the waiting queue one entry a cycle
// and, when no waiting job matches, the run table one slot a cycle, then admits.
// Admission waits until the result register is free. The block takes the next command
// when its controller is idle, even while the previous result still waits on the
// master side.
module job_admission_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [15:0] job_id, [31:16] job_mem
	input  logic [31:0]                   s_tdata,
	// [1:0] func
	input  logic [jac_pkg::FUNC_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] admitted, [16:1] admitted_id, [20:17] running_count, [36:21] mem_in_use, [39:37] zero
	output logic [39:0]                   m_tdata,
	// [2:0] status
	output logic [jac_pkg::STAT_W-1:0]    m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jac_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import jac_pkg::*;

	logic [MEM_W-1:0]   mem_capacity_q;
	logic [LIMIT_W-1:0] max_running_q;
	jac_cmd_t           cmd;
	jac_sts_t           sts;
	logic               admitted;
	logic [ID_W-1:0]    admitted_id;
	logic [CNT_W-1:0]   running_count;
	logic [MEM_W-1:0]   mem_in_use;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_capacity_q <= '0;
			max_running_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_MEM_CAPACITY) begin
				mem_capacity_q <= pwdata[MEM_W-1:0];
			end else begin
				max_running_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MEM_CAPACITY: prdata = {{(32-MEM_W){1'b0}}, mem_capacity_q};
			REG_MAX_RUNNING:  prdata = {{(32-LIMIT_W){1'b0}}, max_running_q};
			default:          prdata = '0;
		endcase
	end

	jac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jac_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_func           (s_tuser),
		.in_id             (s_tdata[15:0]),
		.in_mem            (s_tdata[31:16]),
		.mem_capacity      (mem_capacity_q),
		.max_running       (max_running_q),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_status        (m_tuser),
		.out_admitted      (admitted),
		.out_admitted_id   (admitted_id),
		.out_running_count (running_count),
		.out_mem_in_use    (mem_in_use)
	);

	assign m_tdata = {3'b000, mem_in_use, running_count, admitted_id, admitted};

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command taken while a previous command is still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20:17] <= 4'(RUN_SLOTS)))
		else $error("running count exceeds run table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == '0))
		else $error("admitted id nonzero without admission");

endmodule

// ----- rtl/jac_ctrl.sv -----
// Controller state machine of the job admission controller.
// Sequences decode, waiting-queue search, run-table search and admission. Uses jac_pkg.
module jac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jac_pkg::jac_sts_t sts,
	output jac_pkg::jac_cmd_t cmd
);
	import jac_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_WSRCH  = 5'b00100,
		S_RSRCH  = 5'b01000,
		S_ADMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.func == FUNC_CREATE) begin
					cmd.create = 1'b1;
					state_d    = S_ADMIT;
				end else if (sts.func == FUNC_KILL) begin
					state_d = S_WSRCH;
				end else begin
					state_d = S_ADMIT;
				end
			end
			S_WSRCH: begin
				if (sts.w_end) begin
					cmd.r_start = 1'b1;
					state_d     = S_RSRCH;
				end else if (sts.w_hit) begin
					cmd.w_kill = 1'b1;
					state_d    = S_ADMIT;
				end else begin
					cmd.w_step = 1'b1;
				end
			end
			S_RSRCH: begin
				if (sts.r_end) begin
					cmd.not_found = 1'b1;
					state_d       = S_ADMIT;
				end else if (sts.r_hit) begin
					cmd.r_kill = 1'b1;
					state_d    = S_ADMIT;
				end else begin
					cmd.r_step = 1'b1;
				end
			end
			S_ADMIT: begin
				if (sts.out_free) begin
					cmd.admit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/jac_dp.sv -----
// Datapath of the job admission controller.
// Holds the waiting queue, the run table, the counters and the result register. Uses jac_pkg.
module jac_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jac_pkg::jac_cmd_t            cmd,
	output jac_pkg::jac_sts_t            sts,
	input  logic [jac_pkg::FUNC_W-1:0]   in_func,
	input  logic [jac_pkg::ID_W-1:0]     in_id,
	input  logic [jac_pkg::MEM_W-1:0]    in_mem,
	input  logic [jac_pkg::MEM_W-1:0]    mem_capacity,
	input  logic [jac_pkg::LIMIT_W-1:0]  max_running,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [jac_pkg::STAT_W-1:0]   out_status,
	output logic                         out_admitted,
	output logic [jac_pkg::ID_W-1:0]     out_admitted_id,
	output logic [jac_pkg::CNT_W-1:0]    out_running_count,
	output logic [jac_pkg::MEM_W-1:0]    out_mem_in_use
);
	import jac_pkg::*;

	logic [FUNC_W-1:0]  func_q;
	logic [ID_W-1:0]    id_q;
	logic [MEM_W-1:0]   mem_q;
	logic [STAT_W-1:0]  status_q;
	logic [PTR_W-1:0]   ptr_q;

	logic [ID_W-1:0]    wait_ids_q  [WAIT_DEPTH];
	logic [MEM_W-1:0]   wait_mems_q [WAIT_DEPTH];
	logic [WAIT_CW-1:0] wait_cnt_q;
	logic [ID_W-1:0]    run_ids_q   [RUN_SLOTS];
	logic [MEM_W-1:0]   run_mems_q  [RUN_SLOTS];
	logic [RUN_CW-1:0]  run_cnt_q;
	logic [MEM_W-1:0]   used_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic               out_admitted_q;
	logic [ID_W-1:0]    out_admitted_id_q;
	logic [CNT_W-1:0]   out_running_count_q;
	logic [MEM_W-1:0]   out_mem_in_use_q;

	logic [WAIT_AW-1:0] w_idx;
	logic [RUN_AW-1:0]  r_idx;
	logic [RUN_AW-1:0]  r_tail;
	logic [MEM_W:0]     mem_sum;
	logic               admit_ok;
	logic               do_admit;
	logic               wait_shift;
	logic [RUN_CW-1:0]  run_cnt_next;
	logic [MEM_W-1:0]   used_next;

	assign w_idx  = ptr_q[WAIT_AW-1:0];
	assign r_idx  = ptr_q[RUN_AW-1:0];
	assign r_tail = run_cnt_q[RUN_AW-1:0];

	assign mem_sum  = {1'b0, used_q} + {1'b0, wait_mems_q[0]};
	assign admit_ok = (wait_cnt_q != '0) && (CNT_W'(run_cnt_q) < CNT_W'(max_running))
		&& (run_cnt_q < RUN_CW'(RUN_SLOTS)) && (mem_sum <= {1'b0, mem_capacity});
	assign do_admit = cmd.admit && admit_ok;
	assign wait_shift = cmd.w_kill || do_admit;

	assign run_cnt_next = do_admit ? run_cnt_q + RUN_CW'(1) : run_cnt_q;
	assign used_next    = do_admit ? mem_sum[MEM_W-1:0] : used_q;

	assign sts.func     = func_q;
	assign sts.w_end    = ptr_q >= PTR_W'(wait_cnt_q);
	assign sts.w_hit    = wait_ids_q[w_idx] == id_q;
	assign sts.r_end    = ptr_q >= PTR_W'(run_cnt_q);
	assign sts.r_hit    = run_ids_q[r_idx] == id_q;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			id_q   <= in_id;
			mem_q  <= in_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			status_q <= ST_NOOP;
		end else begin
			if (cmd.load || cmd.r_start) begin
				ptr_q <= '0;
			end else if (cmd.w_step || cmd.r_step) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.load) begin
				status_q <= ST_NOOP;
			end else if (cmd.create) begin
				status_q <= (wait_cnt_q < WAIT_CW'(WAIT_DEPTH)) ? ST_CREATED : ST_QUEUE_FULL;
			end else if (cmd.w_kill) begin
				status_q <= ST_KILLED_WAIT;
			end else if (cmd.r_kill) begin
				status_q <= ST_KILLED_RUN;
			end else if (cmd.not_found) begin
				status_q <= ST_NOT_FOUND;
			end
		end
	end

	// waiting queue: append at tail, close the gap on removal
	always_ff @(posedge clk) begin
		if (cmd.create && (wait_cnt_q < WAIT_CW'(WAIT_DEPTH))) begin
			wait_ids_q[wait_cnt_q[WAIT_AW-1:0]]  <= id_q;
			wait_mems_q[wait_cnt_q[WAIT_AW-1:0]] <= mem_q;
		end else if (wait_shift) begin
			for (int j = 0; j < WAIT_DEPTH - 1; j++) begin
				if (do_admit || (WAIT_AW'(j) >= w_idx)) begin
					wait_ids_q[j]  <= wait_ids_q[j+1];
					wait_mems_q[j] <= wait_mems_q[j+1];
				end
			end
		end
	end

	// run table: kept compact in admission order
	always_ff @(posedge clk) begin
		if (do_admit) begin
			run_ids_q[r_tail]  <= wait_ids_q[0];
			run_mems_q[r_tail] <= wait_mems_q[0];
		end else if (cmd.r_kill) begin
			for (int j = 0; j < RUN_SLOTS - 1; j++) begin
				if (RUN_AW'(j) >= r_idx) begin
					run_ids_q[j]  <= run_ids_q[j+1];
					run_mems_q[j] <= run_mems_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_cnt_q <= '0;
			run_cnt_q  <= '0;
			used_q     <= '0;
		end else begin
			if (cmd.create && (wait_cnt_q < WAIT_CW'(WAIT_DEPTH))) begin
				wait_cnt_q <= wait_cnt_q + WAIT_CW'(1);
			end else if (wait_shift) begin
				wait_cnt_q <= wait_cnt_q - WAIT_CW'(1);
			end
			if (cmd.r_kill) begin
				run_cnt_q <= run_cnt_q - RUN_CW'(1);
				used_q    <= used_q - run_mems_q[r_idx];
			end else begin
				run_cnt_q <= run_cnt_next;
				used_q    <= used_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.admit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.admit) begin
			out_status_q        <= status_q;
			out_admitted_q      <= admit_ok;
			out_admitted_id_q   <= admit_ok ? wait_ids_q[0] : '0;
			out_running_count_q <= CNT_W'(run_cnt_next);
			out_mem_in_use_q    <= used_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_admitted      = out_admitted_q;
	assign out_admitted_id   = out_admitted_id_q;
	assign out_running_count = out_running_count_q;
	assign out_mem_in_use    = out_mem_in_use_q;

endmodule
